// File: sv/htfd_pkg.sv
package htfd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;

  // Full-scale conversion constants
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [16:0] WORD_MAX    = 17'd65535;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [31:0]        serial_number;
    logic               first_crc_ok;
    logic               second_crc_ok;
    logic               frame_ok;
  } out_t;

  // One complete frame handed from the collector to the converter
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        first_ok;
    logic        second_ok;
  } frame_t;

  // CRC-8, MSB first, no reflection, no final xor
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/htfd_frame_collector.sv
module htfd_frame_collector
  import htfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  output logic   frame_valid,
  input  logic   frame_ready,
  output frame_t frame_data
);

  typedef enum logic [2:0] {
    POS_T_HI,
    POS_T_LO,
    POS_T_CRC,
    POS_H_HI,
    POS_H_LO,
    POS_H_CRC
  } pos_t;

  pos_t       pos;
  pos_t       pos_eff;
  pos_t       pos_next;
  logic [7:0] crc;
  logic [7:0] crc_eff;
  logic [7:0] crc_next;
  logic [7:0] crc_fed;
  logic       first_ok;
  logic       first_ok_next;
  logic [7:0] held [4];
  logic       emit;
  logic       accept;

  assign in_ready = !frame_valid || frame_ready;
  assign accept   = in_valid && in_ready;

  // Frame start restarts the frame at byte zero
  assign pos_eff = in_data.frame_start ? POS_T_HI : pos;
  assign crc_eff = in_data.frame_start ? CRC_INIT : crc;
  assign crc_fed = crc_feed(crc_eff, in_data.rx_byte);

  always_comb begin
    pos_next      = POS_T_HI;
    crc_next      = CRC_INIT;
    first_ok_next = first_ok;
    emit          = 1'b0;
    case (pos_eff)
      POS_T_HI: begin
        crc_next = crc_fed;
        pos_next = POS_T_LO;
      end
      POS_T_LO: begin
        crc_next = crc_fed;
        pos_next = POS_T_CRC;
      end
      POS_T_CRC: begin
        first_ok_next = (crc_eff == in_data.rx_byte);
        pos_next      = POS_H_HI;
      end
      POS_H_HI: begin
        crc_next = crc_fed;
        pos_next = POS_H_LO;
      end
      POS_H_LO: begin
        crc_next = crc_fed;
        pos_next = POS_H_CRC;
      end
      POS_H_CRC: begin
        emit = 1'b1;
      end
      default: begin
        pos_next = POS_T_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_T_HI;
      crc         <= CRC_INIT;
      first_ok    <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos      <= pos_next;
        crc      <= crc_next;
        first_ok <= first_ok_next;
      end
      if (accept && emit) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

  // Data bytes and the frame register carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos_eff)
        POS_T_HI: held[0] <= in_data.rx_byte;
        POS_T_LO: held[1] <= in_data.rx_byte;
        POS_H_HI: held[2] <= in_data.rx_byte;
        POS_H_LO: held[3] <= in_data.rx_byte;
        default: ;
      endcase
      if (emit) begin
        frame_data.temp_word <= {held[0], held[1]};
        frame_data.hum_word  <= {held[2], held[3]};
        frame_data.first_ok  <= first_ok;
        frame_data.second_ok <= (crc_eff == in_data.rx_byte);
      end
    end
  end

endmodule

// File: sv/htfd_convert.sv
module htfd_convert
  import htfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   frame_valid,
  output logic   frame_ready,
  input  frame_t frame_data,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  logic        out_take;
  logic        prod_take;
  logic        prod_valid;
  logic [30:0] prod_t;
  logic [29:0] prod_h;
  logic [31:0] prod_serial;
  logic        prod_ok1;
  logic        prod_ok2;

  logic [14:0] q0_t;
  logic [16:0] r_t;
  logic [14:0] q_t;
  logic [15:0] temp16;
  logic [13:0] q0_h;
  logic [16:0] r_h;
  logic [13:0] q_h;
  logic [13:0] hum;

  assign out_take    = !out_valid || out_ready;
  assign prod_take   = !prod_valid || out_take;
  assign frame_ready = prod_take;

  // Divide by 65535: x>>16 plus a single correction, remainder stays below 2*65535
  assign q0_t   = prod_t[30:16];
  assign r_t    = {1'b0, prod_t[15:0]} + 17'(q0_t);
  assign q_t    = q0_t + 15'(r_t >= WORD_MAX);
  assign temp16 = {1'b0, q_t} - TEMP_OFFSET;

  assign q0_h   = prod_h[29:16];
  assign r_h    = {1'b0, prod_h[15:0]} + 17'(q0_h);
  assign q_h    = q0_h + 14'(r_h >= WORD_MAX);

  always_comb begin
    if (q_h < HUM_OFFSET) begin
      hum = '0;
    end else if (q_h - HUM_OFFSET > HUM_MAX) begin
      hum = HUM_MAX;
    end else begin
      hum = q_h - HUM_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_take) begin
        prod_valid <= frame_valid;
      end
      if (out_take) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_take && frame_valid) begin
      prod_t      <= 31'(frame_data.temp_word) * 31'(TEMP_SCALE);
      prod_h      <= 30'(frame_data.hum_word) * 30'(HUM_SCALE);
      prod_serial <= {frame_data.temp_word, frame_data.hum_word};
      prod_ok1    <= frame_data.first_ok;
      prod_ok2    <= frame_data.second_ok;
    end
    if (out_take && prod_valid) begin
      out_data.temperature_centi <= temp16[14:0];
      out_data.humidity_centi    <= hum;
      out_data.serial_number     <= prod_serial;
      out_data.first_crc_ok      <= prod_ok1;
      out_data.second_crc_ok     <= prod_ok2;
      out_data.frame_ok          <= prod_ok1 && prod_ok2;
    end
  end

endmodule

// File: sv/humidity_temp_frame_decoder_unit.sv
// Sensor response decoder. Feed the six response bytes one item per cycle:
// temperature word (high byte, low byte), its CRC-8, humidity word (high,
// low), its CRC-8. Set frame_start on a byte to drop any partial frame and
// take that byte as byte zero; without it bytes are counted cyclically from
// reset. The CRC is polynomial 0x31, init 0xFF, MSB first, no final xor.
// One result item follows each sixth byte: temperature in hundredths of a
// degree C, humidity in hundredths of a percent clamped to 0..10000, the
// 32-bit serial number formed from the four data bytes, and the two CRC
// flags with their AND in frame_ok. Values are always produced; check the
// flags before trusting them. The block takes one byte every cycle while
// in_ready is high; the edge that accepts the sixth byte loads the frame
// register, then the product register loads after the scale multipliers,
// then the output register after the divide-by-65535 correction and clamp,
// which drives out_valid. A stalled output backs up through those registers
// to in_ready.
module humidity_temp_frame_decoder_unit
  import htfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame_data;

  // Track position and CRC, hold data bytes, register each complete frame
  htfd_frame_collector u_collector (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_data  (frame_data)
  );

  // Scale both words and register the result item
  htfd_convert u_convert (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_data  (frame_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !frame_valid |-> in_ready)
    else $error("input stalled with empty frame register");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.humidity_centi <= HUM_MAX)
    else $error("humidity out of range");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.temperature_centi >= -15'sd4500) &&
                  (out_data.temperature_centi <= 15'sd13000))
    else $error("temperature out of range");

  a_frame_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.frame_ok ==
                  (out_data.first_crc_ok && out_data.second_crc_ok))
    else $error("frame_ok does not match CRC flags");
`endif

endmodule
